// ===== hdl/pimu_pkg.sv =====
// Shared types, constants and tables for the planar IMU dead-reckoning block.
`default_nettype none
package pimu_pkg;

  localparam int CordicSteps = 30;
  localparam int StepW       = 5;
  localparam int PcW         = 4;
  localparam logic [StepW-1:0] CordicLast = 5'(CordicSteps - 1);
  localparam logic [PcW-1:0]   LastPc0    = 4'd15;
  localparam logic [PcW-1:0]   LastPc1    = 4'd5;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef enum logic [3:0] {
    A_C, A_S, A_AWX, A_AWY, A_DVX, A_DVY, A_VELX, A_VELY, A_W
  } a_sel_e;

  typedef enum logic [2:0] {
    B_AX, B_AY, B_DT, B_C, B_S
  } b_sel_e;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_LD, ACC_ADD, ACC_SUB
  } acc_op_e;

  typedef enum logic [3:0] {
    ST_NONE, ST_AWX, ST_AWY, ST_DVX, ST_DVY, ST_DPX17, ST_DPX16, ST_DPY17, ST_DPY16,
    ST_YAW, ST_PV, ST_FWD, ST_SIDE
  } st_e;

  typedef enum logic [2:0] {
    S_IDLE, S_CORDIC, S_SINCOS, S_PROG, S_OUT
  } state_e;

  typedef struct packed {
    logic    mul_en;
    a_sel_e  a;
    b_sel_e  b;
    acc_op_e acc;
    st_e     st;
  } uop_t;

  typedef struct packed {
    logic             capture;
    logic             load_fix;
    logic             clear;
    logic             cordic_init;
    logic             cordic_step;
    logic             cordic_done;
    logic [StepW-1:0] step;
    uop_t             uop;
    logic             out_load;
  } dp_cmd_t;

  function automatic logic [31:0] atan_tab(input logic [StepW-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [39:0] v);
    logic [31:0] r;
    if (v > 40'sd2147483647) r = 32'h7FFFFFFF;
    else if (v < -40'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic uop_t mk(input logic m, input a_sel_e a, input b_sel_e b,
                              input acc_op_e c, input st_e s);
    uop_t u;
    u.mul_en = m;
    u.a      = a;
    u.b      = b;
    u.acc    = c;
    u.st     = s;
    return u;
  endfunction

  // phase 0: integrate with old heading; phase 1: body velocity with new heading
  function automatic uop_t ucode(input logic phase, input logic [PcW-1:0] pc);
    uop_t u;
    u = mk(1'b0, A_C, B_AX, ACC_NONE, ST_NONE);
    if (!phase) begin
      case (pc)
        4'd0:  u = mk(1'b1, A_C,    B_AX, ACC_NONE, ST_NONE);
        4'd1:  u = mk(1'b1, A_S,    B_AY, ACC_LD,   ST_NONE);
        4'd2:  u = mk(1'b1, A_S,    B_AX, ACC_SUB,  ST_NONE);
        4'd3:  u = mk(1'b1, A_C,    B_AY, ACC_LD,   ST_AWX);
        4'd4:  u = mk(1'b0, A_C,    B_AX, ACC_ADD,  ST_NONE);
        4'd5:  u = mk(1'b1, A_AWX,  B_DT, ACC_NONE, ST_AWY);
        4'd6:  u = mk(1'b1, A_AWY,  B_DT, ACC_LD,   ST_NONE);
        4'd7:  u = mk(1'b0, A_C,    B_AX, ACC_LD,   ST_DVX);
        4'd8:  u = mk(1'b1, A_DVX,  B_DT, ACC_NONE, ST_DVY);
        4'd9:  u = mk(1'b1, A_VELX, B_DT, ACC_LD,   ST_NONE);
        4'd10: u = mk(1'b1, A_DVY,  B_DT, ACC_LD,   ST_DPX17);
        4'd11: u = mk(1'b1, A_VELY, B_DT, ACC_LD,   ST_DPX16);
        4'd12: u = mk(1'b1, A_W,    B_DT, ACC_LD,   ST_DPY17);
        4'd13: u = mk(1'b0, A_C,    B_AX, ACC_LD,   ST_DPY16);
        4'd14: u = mk(1'b0, A_C,    B_AX, ACC_NONE, ST_YAW);
        4'd15: u = mk(1'b0, A_C,    B_AX, ACC_NONE, ST_PV);
        default: u = mk(1'b0, A_C, B_AX, ACC_NONE, ST_NONE);
      endcase
    end else begin
      case (pc)
        4'd0:  u = mk(1'b1, A_VELX, B_C,  ACC_NONE, ST_NONE);
        4'd1:  u = mk(1'b1, A_VELY, B_S,  ACC_LD,   ST_NONE);
        4'd2:  u = mk(1'b1, A_VELY, B_C,  ACC_ADD,  ST_NONE);
        4'd3:  u = mk(1'b1, A_VELX, B_S,  ACC_LD,   ST_FWD);
        4'd4:  u = mk(1'b0, A_C,    B_AX, ACC_SUB,  ST_NONE);
        4'd5:  u = mk(1'b0, A_C,    B_AX, ACC_NONE, ST_SIDE);
        default: u = mk(1'b0, A_C, B_AX, ACC_NONE, ST_NONE);
      endcase
    end
    return u;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/pimu_if.sv =====
// Input and output word channels of the planar IMU dead-reckoning block.
`default_nettype none
interface pimu_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] accel_x;
  logic signed [31:0] accel_y;
  logic signed [31:0] yaw_rate;
  logic        [15:0] interval;
  logic signed [31:0] fix_x;
  logic signed [31:0] fix_y;
  logic        [31:0] fix_heading;
  modport source(output valid, command, accel_x, accel_y, yaw_rate, interval, fix_x, fix_y,
                 fix_heading, input ready);
  modport sink(input valid, command, accel_x, accel_y, yaw_rate, interval, fix_x, fix_y,
               fix_heading, output ready);
endinterface

interface pimu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic        [31:0] out_heading;
  logic signed [31:0] body_vel_fwd;
  logic signed [31:0] body_vel_side;
  modport source(output valid, out_x, out_y, out_heading, body_vel_fwd, body_vel_side,
                 input ready);
  modport sink(input valid, out_x, out_y, out_heading, body_vel_fwd, body_vel_side,
               output ready);
endinterface
`default_nettype wire

// ===== hdl/planar_imu_dead_reckoning.sv =====
// Planar inertial dead reckoning: top level joining sequencer and datapath.
//
// in_i carries one word per IMU sample (command 0) or pose correction (command 1).
// out_o gives the pose and body-frame velocity for every integrated sample.
// A correction, the first sample after reset and samples that arrive before the
// first correction are taken while idle and give no output word.
// An integrated sample goes from acceptance to out_o.valid through two
// 30-step CORDIC runs (old and new heading) and a 22-step microprogram on one
// shared 35x33 multiplier with a registered product and an accumulator.
// One sample is in flight at a time; in_i.ready is low while it is worked on,
// so a new sample is taken only once the last one is in the output register.
// The output word sits in a register, so the next word is taken while a result
// still waits. If the receiver stalls, the following result holds back in its
// last step until out_o is free, and in_i stays low meanwhile.
// Reset clears pose, velocity and heading and the start-up flags; no output is
// valid after reset.
`default_nettype none
module planar_imu_dead_reckoning (
  input  wire       clk_i,
  input  wire       rst_ni,
  pimu_in_if.sink   in_i,
  pimu_out_if.source out_o
);
  pimu_pkg::dp_cmd_t cmd;

  pimu_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_i.ready),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .cmd_o        (cmd)
  );

  pimu_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .accel_x_i       (in_i.accel_x),
    .accel_y_i       (in_i.accel_y),
    .yaw_rate_i      (in_i.yaw_rate),
    .interval_i      (in_i.interval),
    .fix_x_i         (in_i.fix_x),
    .fix_y_i         (in_i.fix_y),
    .fix_heading_i   (in_i.fix_heading),
    .out_x_o         (out_o.out_x),
    .out_y_o         (out_o.out_y),
    .out_heading_o   (out_o.out_heading),
    .body_vel_fwd_o  (out_o.body_vel_fwd),
    .body_vel_side_o (out_o.body_vel_side)
  );

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_o.valid) else $error("output word not presented");
  a_fix_nonblock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_fix |=> in_i.ready) else $error("correction blocked input");
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.out_load)) else $error("valid without load");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cordic_init && in_i.ready |=> !in_i.ready) else $error("input open during work");
endmodule
`default_nettype wire

// ===== hdl/pimu_ctrl.sv =====
// Sequencer: handshakes, start-up flags, CORDIC counting and microprogram stepping.
`default_nettype none
module pimu_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire                 in_command_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output pimu_pkg::dp_cmd_t   cmd_o
);
  pimu_pkg::state_e state_q, state_d;
  logic [pimu_pkg::StepW-1:0] cnt_q, cnt_d;
  logic [pimu_pkg::PcW-1:0]   pc_q, pc_d;
  logic phase_q, phase_d, first_q, first_d, ready_q, ready_d, oval_q, oval_d;
  logic acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pimu_pkg::S_IDLE;
      cnt_q   <= '0;
      pc_q    <= '0;
      phase_q <= 1'b0;
      first_q <= 1'b0;
      ready_q <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pc_q    <= pc_d;
      phase_q <= phase_d;
      first_q <= first_d;
      ready_q <= ready_d;
      oval_q  <= oval_d;
    end
  end

  assign in_ready_o  = (state_q == pimu_pkg::S_IDLE);
  assign out_valid_o = oval_q;
  assign acc         = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pc_d    = pc_q;
    phase_d = phase_q;
    first_d = first_q;
    ready_d = ready_q;
    oval_d  = oval_q && !out_ready_i;
    cmd_o   = '0;
    cmd_o.step = cnt_q;
    cmd_o.uop  = pimu_pkg::ucode(phase_q, pc_q);
    if (state_q != pimu_pkg::S_PROG) cmd_o.uop = pimu_pkg::ucode(1'b1, pimu_pkg::LastPc0);
    case (state_q)
      pimu_pkg::S_IDLE: begin
        if (acc) begin
          if (in_command_i) begin
            cmd_o.load_fix = 1'b1;
            ready_d = 1'b1;
          end else if (!first_q) begin
            cmd_o.clear = 1'b1;
            first_d = 1'b1;
          end else if (ready_q) begin
            cmd_o.capture     = 1'b1;
            cmd_o.cordic_init = 1'b1;
            cnt_d   = '0;
            phase_d = 1'b0;
            state_d = pimu_pkg::S_CORDIC;
          end
        end
      end
      pimu_pkg::S_CORDIC: begin
        cmd_o.cordic_step = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == pimu_pkg::CordicLast) state_d = pimu_pkg::S_SINCOS;
      end
      pimu_pkg::S_SINCOS: begin
        cmd_o.cordic_done = 1'b1;
        pc_d    = '0;
        state_d = pimu_pkg::S_PROG;
      end
      pimu_pkg::S_PROG: begin
        pc_d = pc_q + 4'd1;
        if (!phase_q && pc_q == pimu_pkg::LastPc0) begin
          cmd_o.cordic_init = 1'b1;
          cnt_d   = '0;
          phase_d = 1'b1;
          state_d = pimu_pkg::S_CORDIC;
        end else if (phase_q && pc_q == pimu_pkg::LastPc1) begin
          state_d = pimu_pkg::S_OUT;
        end
      end
      pimu_pkg::S_OUT: begin
        if (!oval_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          oval_d  = 1'b1;
          state_d = pimu_pkg::S_IDLE;
        end
      end
      default: state_d = pimu_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/pimu_dp.sv =====
// Datapath: pose state, CORDIC sine/cosine, shared multiplier with accumulator, output word.
`default_nettype none
module pimu_dp (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  pimu_pkg::dp_cmd_t        cmd_i,
  input  wire signed [31:0]        accel_x_i,
  input  wire signed [31:0]        accel_y_i,
  input  wire signed [31:0]        yaw_rate_i,
  input  wire        [15:0]        interval_i,
  input  wire signed [31:0]        fix_x_i,
  input  wire signed [31:0]        fix_y_i,
  input  wire        [31:0]        fix_heading_i,
  output logic signed [31:0]       out_x_o,
  output logic signed [31:0]       out_y_o,
  output logic        [31:0]       out_heading_o,
  output logic signed [31:0]       body_vel_fwd_o,
  output logic signed [31:0]       body_vel_side_o
);
  logic signed [31:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;
  logic        [31:0] yaw_q;
  logic signed [31:0] ax_q, ay_q, w_q;
  logic        [15:0] dt_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic               flip_q;
  logic signed [31:0] c_q, s_q;
  logic signed [34:0] awx_q, awy_q, dvx_q, dvy_q;
  logic signed [35:0] dpx_q, dpy_q;
  logic signed [31:0] fwd_q, side_q;
  logic signed [67:0] p_q;
  logic signed [68:0] acc_q, acc_d;
  logic signed [34:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [68:0] r16, r17, r30, r32, p_ext;
  logic signed [33:0] dx, dy, atn;
  logic        [31:0] ang;
  logic               fl;

  assign p_ext = {p_q[67], p_q};
  assign r16 = acc_q + 69'sd32768;
  assign r17 = acc_q + 69'sd65536;
  assign r30 = acc_q + 69'sd536870912;
  assign r32 = acc_q + 69'sd2147483648;
  assign dx  = cy_q >>> cmd_i.step;
  assign dy  = cx_q >>> cmd_i.step;
  assign atn = {2'b00, pimu_pkg::atan_tab(cmd_i.step)};
  assign fl  = (yaw_q[31:30] == 2'b01) || (yaw_q[31:30] == 2'b10);
  assign ang = fl ? (yaw_q ^ 32'h80000000) : yaw_q;

  always_comb begin
    case (cmd_i.uop.a)
      pimu_pkg::A_C:    mul_a = {{3{c_q[31]}}, c_q};
      pimu_pkg::A_S:    mul_a = {{3{s_q[31]}}, s_q};
      pimu_pkg::A_AWX:  mul_a = awx_q;
      pimu_pkg::A_AWY:  mul_a = awy_q;
      pimu_pkg::A_DVX:  mul_a = dvx_q;
      pimu_pkg::A_DVY:  mul_a = dvy_q;
      pimu_pkg::A_VELX: mul_a = {{3{vel_x_q[31]}}, vel_x_q};
      pimu_pkg::A_VELY: mul_a = {{3{vel_y_q[31]}}, vel_y_q};
      pimu_pkg::A_W:    mul_a = {{3{w_q[31]}}, w_q};
      default:          mul_a = '0;
    endcase
    case (cmd_i.uop.b)
      pimu_pkg::B_AX: mul_b = {ax_q[31], ax_q};
      pimu_pkg::B_AY: mul_b = {ay_q[31], ay_q};
      pimu_pkg::B_DT: mul_b = {17'd0, dt_q};
      pimu_pkg::B_C:  mul_b = {c_q[31], c_q};
      pimu_pkg::B_S:  mul_b = {s_q[31], s_q};
      default:        mul_b = '0;
    endcase
    case (cmd_i.uop.acc)
      pimu_pkg::ACC_LD:  acc_d = p_ext;
      pimu_pkg::ACC_ADD: acc_d = acc_q + p_ext;
      pimu_pkg::ACC_SUB: acc_d = acc_q - p_ext;
      default:           acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.uop.mul_en) p_q <= mul_a * mul_b;
    acc_q <= acc_d;
    if (cmd_i.capture) begin
      ax_q <= accel_x_i;
      ay_q <= accel_y_i;
      w_q  <= yaw_rate_i;
      dt_q <= interval_i;
    end
    if (cmd_i.cordic_init) begin
      cx_q   <= pimu_pkg::CordicGain;
      cy_q   <= '0;
      cz_q   <= {{2{ang[31]}}, ang};
      flip_q <= fl;
    end else if (cmd_i.cordic_step) begin
      if (!cz_q[33]) begin
        cx_q <= cx_q - dx;
        cy_q <= cy_q + dy;
        cz_q <= cz_q - atn;
      end else begin
        cx_q <= cx_q + dx;
        cy_q <= cy_q - dy;
        cz_q <= cz_q + atn;
      end
    end
    if (cmd_i.cordic_done) begin
      c_q <= flip_q ? -cx_q[31:0] : cx_q[31:0];
      s_q <= flip_q ? -cy_q[31:0] : cy_q[31:0];
    end
    case (cmd_i.uop.st)
      pimu_pkg::ST_AWX:   awx_q <= r30[64:30];
      pimu_pkg::ST_AWY:   awy_q <= r30[64:30];
      pimu_pkg::ST_DVX:   dvx_q <= r16[50:16];
      pimu_pkg::ST_DVY:   dvy_q <= r16[50:16];
      pimu_pkg::ST_DPX17: dpx_q <= {{2{r17[50]}}, r17[50:17]};
      pimu_pkg::ST_DPX16: dpx_q <= dpx_q + {{3{r16[48]}}, r16[48:16]};
      pimu_pkg::ST_DPY17: dpy_q <= {{2{r17[50]}}, r17[50:17]};
      pimu_pkg::ST_DPY16: dpy_q <= dpy_q + {{3{r16[48]}}, r16[48:16]};
      pimu_pkg::ST_FWD:   fwd_q <= pimu_pkg::sat32({{3{r30[66]}}, r30[66:30]});
      pimu_pkg::ST_SIDE:  side_q <= pimu_pkg::sat32({{3{r30[66]}}, r30[66:30]});
      default: ;
    endcase
    if (cmd_i.out_load) begin
      out_x_o         <= pos_x_q;
      out_y_o         <= pos_y_q;
      out_heading_o   <= yaw_q;
      body_vel_fwd_o  <= fwd_q;
      body_vel_side_o <= side_q;
    end
  end

  // pose state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      vel_x_q <= '0;
      vel_y_q <= '0;
      yaw_q   <= '0;
    end else if (cmd_i.load_fix) begin
      pos_x_q <= fix_x_i;
      pos_y_q <= fix_y_i;
      yaw_q   <= fix_heading_i;
    end else if (cmd_i.clear) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      vel_x_q <= '0;
      vel_y_q <= '0;
      yaw_q   <= '0;
    end else if (cmd_i.uop.st == pimu_pkg::ST_YAW) begin
      yaw_q <= yaw_q + r32[63:32];
    end else if (cmd_i.uop.st == pimu_pkg::ST_PV) begin
      pos_x_q <= pimu_pkg::sat32({{8{pos_x_q[31]}}, pos_x_q} + {{4{dpx_q[35]}}, dpx_q});
      pos_y_q <= pimu_pkg::sat32({{8{pos_y_q[31]}}, pos_y_q} + {{4{dpy_q[35]}}, dpy_q});
      vel_x_q <= pimu_pkg::sat32({{8{vel_x_q[31]}}, vel_x_q} + {{5{dvx_q[34]}}, dvx_q});
      vel_y_q <= pimu_pkg::sat32({{8{vel_y_q[31]}}, vel_y_q} + {{5{dvy_q[34]}}, dvy_q});
    end
  end
endmodule
`default_nettype wire

// ===== sim/pimu_checker.sv =====
// Checker for the planar IMU dead-reckoning block: predicts pose words and compares them.
`timescale 1ns / 1ps
module pimu_checker (
  input  wire        clk_i,
  input  wire        rst_ni,
  pimu_in_if.sink    in_mon,
  pimu_out_if.sink   out_mon,
  output int         fail_cnt_o,
  output int         pending_o
);
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] hdg;
    logic [31:0] fwd;
    logic [31:0] side;
  } pose_t;

  localparam logic CMD_FIX = 1'b1;

  pose_t pose_q[$];
  longint px, py, vx, vy;
  logic [31:0] hdg;
  bit started, armed;

  function automatic longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint rnd(longint v, int n);
    return fshr(v + (longint'(1) << (n - 1)), n);
  endfunction

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_at(int i);
    longint t[30] = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98,
      64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE,
      64'h0000145F, 64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3,
      64'h00000051, 64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003,
      64'h00000001};
    return t[i];
  endfunction

  task automatic rotor(input logic [31:0] ang, output longint c, output longint s);
    bit flip;
    longint x, y, z, dx, dy;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang[31] = ~ang[31];
    z = longint'($signed(ang));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_at(i);
      end else begin
        x += dx; y -= dy; z += atan_at(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic integrate(input longint ax, ay, w, dt);
    longint c, s, awx, awy, dvx, dvy, dpx, dpy;
    pose_t p;
    rotor(hdg, c, s);
    awx = rnd(c * ax - s * ay, 30);
    awy = rnd(s * ax + c * ay, 30);
    dvx = rnd(awx * dt, 16);
    dvy = rnd(awy * dt, 16);
    dpx = rnd(vx * dt, 16) + rnd(dvx * dt, 17);
    dpy = rnd(vy * dt, 16) + rnd(dvy * dt, 17);
    px = sat(px + dpx);
    py = sat(py + dpy);
    vx = sat(vx + dvx);
    vy = sat(vy + dvy);
    hdg = hdg + 32'(rnd(w * dt, 32));
    rotor(hdg, c, s);
    p.x = 32'(px);
    p.y = 32'(py);
    p.hdg = hdg;
    p.fwd = 32'(sat(rnd(vx * c + vy * s, 30)));
    p.side = 32'(sat(rnd(vy * c - vx * s, 30)));
    pose_q.push_back(p);
  endtask

  task automatic report(input string what, input logic [31:0] got, want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_cnt_o++;
  endtask

  initial fail_cnt_o = 0;
  assign pending_o = pose_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    pose_t e;
    if (!rst_ni) begin
      px = 0; py = 0; vx = 0; vy = 0; hdg = 0;
      started = 0; armed = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command == CMD_FIX) begin
          px = longint'(in_mon.fix_x);
          py = longint'(in_mon.fix_y);
          hdg = in_mon.fix_heading;
          armed = 1;
        end else if (!started) begin
          started = 1;
          px = 0; py = 0; vx = 0; vy = 0; hdg = 0;
        end else if (armed) begin
          integrate(longint'(in_mon.accel_x), longint'(in_mon.accel_y),
                    longint'(in_mon.yaw_rate), longint'({1'b0, in_mon.interval}));
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pose_q.size() == 0) begin
          $display("unexpected output word at %0t", $realtime);
          fail_cnt_o++;
        end else begin
          e = pose_q.pop_front();
          if (out_mon.out_x !== e.x) report("out_x", out_mon.out_x, e.x);
          if (out_mon.out_y !== e.y) report("out_y", out_mon.out_y, e.y);
          if (out_mon.out_heading !== e.hdg) report("out_heading", out_mon.out_heading, e.hdg);
          if (out_mon.body_vel_fwd !== e.fwd) report("body_vel_fwd", out_mon.body_vel_fwd, e.fwd);
          if (out_mon.body_vel_side !== e.side)
            report("body_vel_side", out_mon.body_vel_side, e.side);
        end
      end
    end
  end
endmodule

// ===== sim/tb_top.sv =====
// Top of the planar IMU dead-reckoning testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  localparam logic CMD_IMU = 1'b0;
  localparam logic CMD_FIX = 1'b1;
  localparam longint Limit = 4_000_000;

  logic clk_i, rst_ni;
  int fail_cnt, pending;
  longint cycles;

  pimu_in_if  in_i();
  pimu_out_if out_o();

  planar_imu_dead_reckoning dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_i), .out_o(out_o));
  pimu_checker chk (.clk_i(clk_i), .rst_ni(rst_ni), .in_mon(in_i), .out_mon(out_o),
                    .fail_cnt_o(fail_cnt), .pending_o(pending));

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      3: return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  // receiver stalls
  initial begin
    int n;
    out_o.ready = 0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 3) == 0) begin
        n = gap();
        if (n > 0) begin
          out_o.ready <= 0;
          repeat (n) @(negedge clk_i);
        end
      end
      out_o.ready <= 1;
    end
  end

  task automatic send(input logic cmd, input logic [31:0] ax, ay, w, input logic [15:0] dt,
                      input logic [31:0] fx, fy, fh);
    int n;
    n = gap();
    if (n > 0) begin
      in_i.valid <= 0;
      repeat (n) @(negedge clk_i);
    end
    in_i.valid <= 1;
    in_i.command <= cmd;
    in_i.accel_x <= ax; in_i.accel_y <= ay; in_i.yaw_rate <= w; in_i.interval <= dt;
    in_i.fix_x <= fx; in_i.fix_y <= fy; in_i.fix_heading <= fh;
    @(posedge clk_i);
    while (!in_i.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic imu(input logic [31:0] ax, ay, w, input logic [15:0] dt);
    send(CMD_IMU, ax, ay, w, dt, $urandom, $urandom, $urandom);
  endtask

  task automatic fix(input logic [31:0] fx, fy, fh);
    send(CMD_FIX, $urandom, $urandom, $urandom, 16'($urandom), fx, fy, fh);
  endtask

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > Limit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_i.valid = 0; in_i.command = CMD_IMU;
    in_i.accel_x = 0; in_i.accel_y = 0; in_i.yaw_rate = 0; in_i.interval = 0;
    in_i.fix_x = 0; in_i.fix_y = 0; in_i.fix_heading = 0;
    rst_ni = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    // directed: first sample after reset, correction, first integrated sample
    imu(32'h00010000, 0, 0, 16'h1000);
    fix(32'h00050000, 32'hFFFB0000, 32'h40000000);
    imu(32'h00010000, 32'h00020000, 32'h10000000, 16'h1000);
    imu(32'h00010000, 32'h00020000, 32'h10000000, 16'h1000);
    fix(32'h7FFFFFFF, 32'h80000000, 32'hC0000000);
    imu(32'h00010000, 32'h00010000, 0, 16'h0000);
    imu(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF);
    imu(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 16'hFFFF);
    imu(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF);
    fix(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    imu(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 16'h0001);
    fix(0, 0, 32'hFFFFFFFF);
    imu(32'hFFFFFFFF, 32'h00000001, 32'h00000001, 16'h8000);
    fix(0, 0, 32'h3FFFFFFF);
    imu(32'h00008000, 32'hFFFF8000, 32'h40000000, 16'h4000);
    // hold off until all pose words are back
    in_i.valid <= 0;
    while (pending != 0) @(negedge clk_i);
    for (int n = 0; n < 1135; n++) begin
      if ($urandom_range(0, 19) == 0)
        fix(rnd_word(), rnd_word(), $urandom);
      else if ($urandom_range(0, 3) == 0)
        imu(rnd_word(), rnd_word(), rnd_word(), 16'($urandom));
      else
        imu(32'(int'($urandom_range(0, 1 << 21)) - (1 << 20)),
            32'(int'($urandom_range(0, 1 << 21)) - (1 << 20)),
            $urandom, 16'($urandom_range(0, 2000)));
    end
    in_i.valid <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== planar_imu_dead_reckoning.f =====
hdl/pimu_pkg.sv
hdl/pimu_if.sv
hdl/pimu_ctrl.sv
hdl/pimu_dp.sv
hdl/planar_imu_dead_reckoning.sv
sim/pimu_checker.sv
sim/tb_top.sv
